// ===== rtl/core/dvep_pkg.sv =====
// ----------------------------------------------------------------------------
// dvep_pkg
// Shared types, constants and helpers of the delta prefix-code packer.
// ----------------------------------------------------------------------------
package dvep_pkg;

    // Action codes carried in the input tuser field
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ESC_CODE = 1'b0;
    localparam logic CFG_ESC_LEN  = 1'b1;

    // Fixed field and code geometry
    localparam int FIELD_CODE_BITS = 24;
    localparam int MAX_CODE_LEN    = 24;
    localparam int LEN_LIM         = (MAX_CODE_LEN < FIELD_CODE_BITS) ?
                                     MAX_CODE_LEN : FIELD_CODE_BITS;
    localparam int ESCAPE_KEY      = -666;
    localparam int RAW_BITS        = 16;
    localparam int WORD_BITS       = 16;
    localparam int DIFF_W          = 17;

    // Escape token settings, already clamped
    typedef struct packed {
        logic [23:0] code;
        logic [4:0]  len;
    } t_esc_cfg;

    // One coded item handed from the front end to the packer
    typedef struct packed {
        logic        is_end;
        logic        esc;
        logic [23:0] code;
        logic [4:0]  len;
        logic [15:0] raw;
    } t_item;

    // Clamp a code length to the longest supported code
    function automatic logic [4:0] clamp_len(input logic [4:0] len);
        logic [4:0] lim;
        lim = 5'(LEN_LIM);
        return (len > lim) ? lim : len;
    endfunction

endpackage

// ===== rtl/core/dvep_front.sv =====
// ----------------------------------------------------------------------------
// dvep_front
// Input stage: delta computation, code table memory with registered read,
// table loads and the table clearing pass after reset.
// ----------------------------------------------------------------------------
module dvep_front import dvep_pkg::*; #(
    parameter int DIFF_LIMIT  = 200,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_sample,
    input  logic        i_start,
    input  logic [8:0]  i_entry_index,
    input  logic [23:0] i_entry_code,
    input  logic [4:0]  i_entry_length,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_adv
);

    localparam int SLOTS  = 2 * DIFF_LIMIT + 1;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam logic signed [DIFF_W-1:0] DL_POS = DIFF_W'(DIFF_LIMIT);
    localparam logic signed [DIFF_W-1:0] DL_NEG = -DL_POS;
    localparam logic signed [DIFF_W-1:0] KEY_S  = DIFF_W'(ESCAPE_KEY);

    logic [28:0] mem [SLOTS];

    logic                     r_clr_busy;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic [SAMPLE_BITS-1:0]   r_prev;
    logic                     r_valid;
    logic                     r_is_end;
    logic                     r_use;
    logic [15:0]              r_raw;
    logic [28:0]              r_rdata;

    logic                     acc;
    logic [SAMPLE_BITS-1:0]   smp;
    logic [SAMPLE_BITS-1:0]   raw_s;
    logic signed [DIFF_W-1:0] diff;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     use_tab;
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [28:0]              wdata;

    assign o_ready = !r_clr_busy && (!r_valid || i_adv);
    assign acc     = i_valid && o_ready;

    // Delta against the previous sample, sign extended
    assign smp     = i_sample[SAMPLE_BITS-1:0];
    assign raw_s   = i_start ? '0 : (smp - r_prev);
    assign diff    = {{(DIFF_W-SAMPLE_BITS){raw_s[SAMPLE_BITS-1]}}, raw_s};
    assign use_tab = (diff != KEY_S) && (diff >= DL_NEG) && (diff <= DL_POS);
    // Keep the read address inside the table when no slot applies
    assign rd_addr = use_tab ? ADDR_W'(diff + DL_POS) : '0;

    // Select the table write: clearing pass first, then loads
    always_comb begin
        we    = 1'b0;
        waddr = r_clr_addr;
        wdata = '0;
        if (r_clr_busy) begin
            we = 1'b1;
        end else if (acc && i_action == ACT_LOAD &&
                     32'(i_entry_index) < 32'(SLOTS)) begin
            we    = 1'b1;
            waddr = ADDR_W'(i_entry_index);
            wdata = {i_entry_code, clamp_len(i_entry_length)};
        end
    end

    // Code table memory with registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (acc) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Clearing pass and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_prev     <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(SLOTS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (acc) begin
                r_valid <= (i_action == ACT_SAMPLE) || (i_action == ACT_END);
                if (i_action == ACT_SAMPLE) begin
                    r_prev <= smp;
                end
            end else if (i_adv) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_is_end <= (i_action == ACT_END);
            r_use    <= use_tab && (i_action == ACT_SAMPLE);
            r_raw    <= diff[15:0];
        end
    end

    assign o_valid       = r_valid;
    assign o_item.is_end = r_is_end;
    assign o_item.esc    = !(r_use && (r_rdata[4:0] != 5'd0));
    assign o_item.code   = r_rdata[28:5];
    assign o_item.len    = r_rdata[4:0];
    assign o_item.raw    = r_raw;

`ifndef SYNTHESIS
    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_ready)
        else $error("input taken during table clearing");
    a_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_adv) |=> (r_valid && $stable(r_rdata) && $stable(r_raw)))
        else $error("stalled item changed");
`endif

endmodule

// ===== rtl/core/dvep_packer.sv =====
// ----------------------------------------------------------------------------
// dvep_packer
// Bit packer: appends code bits to the pending bits, cuts 16-bit words MSB
// first and holds up to three result words for the output stream.
// ----------------------------------------------------------------------------
module dvep_packer import dvep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_adv,
    input  t_esc_cfg    i_esc,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast
);

    localparam int CAT_W = 56;

    logic [14:0] r_pbits;
    logic [3:0]  r_pcnt;
    logic [1:0]  r_cnt;
    logic [15:0] r_word [3];
    logic [2:0]  r_last;

    logic [14:0] n_pbits;
    logic [3:0]  n_pcnt;
    logic [1:0]  n_cnt;
    logic [15:0] n_word [3];
    logic [2:0]  n_last;

    logic [5:0]       l1;
    logic [5:0]       l2;
    logic [5:0]       tot;
    logic [23:0]      c1;
    logic [15:0]      c2;
    logic [CAT_W-1:0] cat;
    logic [CAT_W-1:0] aligned;
    logic [1:0]       nw;
    logic [3:0]       rem;
    logic             fire;
    logic             ld;

    // Pick the code pieces for this item
    always_comb begin
        if (i_item.is_end) begin
            l1 = {1'b0, i_esc.len};
            c1 = i_esc.code;
            l2 = 6'd0;
            c2 = '0;
        end else if (i_item.esc) begin
            l1 = {1'b0, i_esc.len};
            c1 = i_esc.code;
            l2 = 6'(RAW_BITS);
            c2 = i_item.raw;
        end else begin
            l1 = {1'b0, i_item.len};
            c1 = i_item.code;
            l2 = 6'd0;
            c2 = '0;
        end
    end

    // Concatenate pending and new bits, then left align
    assign tot = 6'(r_pcnt) + l1 + l2;
    assign cat = (CAT_W'(r_pbits) << (l1 + l2))
               | ((CAT_W'(c1) & ~({CAT_W{1'b1}} << l1)) << l2)
               | (CAT_W'(c2) & ~({CAT_W{1'b1}} << l2));
    assign aligned = cat << (6'(CAT_W) - tot);
    assign rem     = tot[3:0];
    assign nw      = tot[5:4] + ((i_item.is_end && rem != 4'd0) ? 2'd1 : 2'd0);

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = r_word[0];
    assign o_m_tlast  = r_last[0];
    assign fire       = o_m_tvalid && i_m_tready;
    assign ld         = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_m_tready);
    assign o_adv      = ld;

    // Shift out delivered words, load the next item's words
    always_comb begin
        n_pbits = r_pbits;
        n_pcnt  = r_pcnt;
        n_cnt   = r_cnt;
        n_word  = r_word;
        n_last  = r_last;
        if (fire) begin
            n_word[0] = r_word[1];
            n_word[1] = r_word[2];
            n_last    = {1'b0, r_last[2:1]};
            n_cnt     = r_cnt - 2'd1;
        end
        if (ld && i_valid) begin
            n_word[0] = aligned[55:40];
            n_word[1] = aligned[39:24];
            n_word[2] = aligned[23:8];
            n_cnt     = nw;
            for (int k = 0; k < 3; k++) begin
                n_last[k] = i_item.is_end && (2'(k) == nw - 2'd1);
            end
            if (i_item.is_end) begin
                n_pbits = '0;
                n_pcnt  = '0;
            end else begin
                n_pbits = cat[14:0] & ~(15'h7fff << rem);
                n_pcnt  = rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits <= '0;
            r_pcnt  <= '0;
            r_cnt   <= '0;
        end else begin
            r_pbits <= n_pbits;
            r_pcnt  <= n_pcnt;
            r_cnt   <= n_cnt;
        end
    end

    // Result words carry no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_last <= n_last;
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && i_valid && i_item.is_end) |=> (r_pcnt == 4'd0 && r_pbits == 15'd0))
        else $error("pending bits left after end of read");
    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0 && r_last[0]) |-> (r_cnt == 2'd1))
        else $error("word marked last is not the final buffered word");
`endif

endmodule

// ===== rtl/core/delta_vlc_escape_packer.sv =====
// Path: an accepted input is registered in the front end's item register and
// then in the packer's result word buffer, which drives tvalid and tdata.
// Throughput: one input per cycle while each item yields at most one word and
// m_tready is high; the next item waits while more than one word is buffered.
// Reset: synchronous; a clearing pass over all 2*DIFF_LIMIT+1 slots (401 by
// default) wipes the code table, s_tready low; config writes are taken throughout.
// ----------------------------------------------------------------------------
// delta_vlc_escape_packer
// Delta prefix-code encoder with escape tokens, packing into 16-bit words.
// ----------------------------------------------------------------------------
module delta_vlc_escape_packer import dvep_pkg::*; #(
    parameter int DIFF_LIMIT  = 200,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample[15:0], start_of_read[16], entry_index[25:17],
    // entry_code[49:26], entry_length[54:50], zero[55]
    input  logic [55:0] i_s_tdata,
    // action[1:0]
    input  logic [1:0]  i_s_tuser,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // packed_word[15:0]
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    logic [23:0] r_esc_code;
    logic [4:0]  r_esc_len;
    logic [4:0]  esc_len_c;
    t_esc_cfg    esc;
    logic        f_valid;
    t_item       f_item;
    logic        adv;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_code <= '0;
            r_esc_len  <= 5'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ESC_CODE: r_esc_code <= i_cfg_data;
                CFG_ESC_LEN:  r_esc_len  <= i_cfg_data[4:0];
                default:      r_esc_len  <= r_esc_len;
            endcase
        end
    end

    // Clamp the escape length, zero counts as one
    assign esc_len_c = clamp_len(r_esc_len);
    assign esc.code  = r_esc_code;
    assign esc.len   = (esc_len_c == 5'd0) ? 5'd1 : esc_len_c;

    dvep_front #(
        .DIFF_LIMIT  (DIFF_LIMIT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_action       (i_s_tuser),
        .i_sample       (i_s_tdata[15:0]),
        .i_start        (i_s_tdata[16]),
        .i_entry_index  (i_s_tdata[25:17]),
        .i_entry_code   (i_s_tdata[49:26]),
        .i_entry_length (i_s_tdata[54:50]),
        .o_valid        (f_valid),
        .o_item         (f_item),
        .i_adv          (adv)
    );

    dvep_packer u_packer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f_valid),
        .i_item     (f_item),
        .o_adv      (adv),
        .i_esc      (esc),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
